[src/sitda_pkg.sv]
// Package for the signed integer to decimal ASCII unit: types, codes and the power-of-ten table.
package sitda_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 6;
  localparam int unsigned TrialW = 36;  // holds 8 * 10^9 and the borrow bit
  localparam int unsigned PosW   = 4;   // digit position 9..0
  localparam int unsigned BitW   = 2;   // BCD bit weight 3..0
  localparam int unsigned DigitW = 4;

  localparam logic [PosW-1:0]   TopPos    = 4'd9;
  localparam logic [BitW-1:0]   TopBit    = 2'd3;
  localparam logic [CharW-1:0]  ChMinus   = 6'd45;  // '-' in 6 bits
  localparam logic [CharW-1:0]  ChZero    = 6'd48;  // '0' in 6 bits
  localparam logic [CharW-1:0]  ChNine    = 6'd57;  // '9' in 6 bits

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // 10^pos scaled by 2^b, the trial subtrahend for one restoring step
  function automatic logic [TrialW-1:0] digit_weight(input logic [PosW-1:0] pos,
                                                     input logic [BitW-1:0] b);
    logic [TrialW-1:0] p;
    case (pos)
      4'd0:    p = 36'd1;
      4'd1:    p = 36'd10;
      4'd2:    p = 36'd100;
      4'd3:    p = 36'd1000;
      4'd4:    p = 36'd10000;
      4'd5:    p = 36'd100000;
      4'd6:    p = 36'd1000000;
      4'd7:    p = 36'd10000000;
      4'd8:    p = 36'd100000000;
      4'd9:    p = 36'd1000000000;
      default: p = '0;
    endcase
    return p << b;
  endfunction

endpackage

[src/signed_int_to_decimal_ascii_unit.sv]
// Signed 32-bit integer to decimal ASCII text converter, one character per strobe.
//
// Usage: drive in_value and raise start; the transfer happens at a clock edge
// where start is high and busy is low. busy stays high while the number is
// being converted. Characters come out most significant first on out_character,
// each valid for exactly one cycle with out_valid high; out_last marks the
// final digit. A negative number gives '-' first; leading zeros are dropped and
// zero gives a single "0". The most negative value gives "-2147483648".
// Operation: one shared 36-bit compare-subtract unit finds each decimal digit by
// four restoring steps against 8, 4, 2 and 1 times its power of ten, for ten
// positions from 10^9 down to 10^0; busy stays high through all of them and,
// for a negative number, through the sign state before them. The minus sign is
// shown first, then each digit once its last restoring step is done. The last
// character is shown in the cycle in which busy drops, so a new number may be
// started right then.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid. The receiver cannot stall; every strobe is a completed transfer.
module signed_int_to_decimal_ascii_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sitda_pkg::ValueW-1:0] in_value,
  output logic                              out_valid,
  output logic [sitda_pkg::CharW-1:0]       out_character,
  output logic                              out_last
);

  sitda_pkg::state_t state_r, state_nxt;

  logic [sitda_pkg::ValueW-1:0] mag_r, mag_nxt;
  logic [sitda_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [sitda_pkg::BitW-1:0]   bit_r, bit_nxt;
  logic [sitda_pkg::DigitW-1:0] digit_r, digit_nxt;
  logic                         started_r, started_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CharW-1:0]  out_character_r, out_character_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  logic [sitda_pkg::TrialW-1:0] trial;
  logic                         ge;
  logic [sitda_pkg::DigitW-1:0] digit_full;
  logic                         emit;

  assign accept = start && (state_r == sitda_pkg::ST_IDLE);
  assign busy   = (state_r != sitda_pkg::ST_IDLE);

  // shared compare-subtract unit
  assign trial      = {{(sitda_pkg::TrialW-sitda_pkg::ValueW){1'b0}}, mag_r}
                      - sitda_pkg::digit_weight(pos_r, bit_r);
  assign ge         = !trial[sitda_pkg::TrialW-1];
  assign digit_full = digit_r | (ge ? (sitda_pkg::DigitW'(1) << bit_r) : '0);
  // leading zeros suppressed, but the units digit always goes out
  assign emit       = (bit_r == '0)
                      && ((digit_full != '0) || started_r || (pos_r == '0));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sitda_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = in_value[sitda_pkg::ValueW-1] ? sitda_pkg::ST_SIGN
                                                    : sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        state_nxt = sitda_pkg::ST_DIGIT;
      end
      sitda_pkg::ST_DIGIT: begin
        if ((bit_r == '0) && (pos_r == '0)) begin
          state_nxt = sitda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sitda_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mag_nxt           = mag_r;
    pos_nxt           = pos_r;
    bit_nxt           = bit_r;
    digit_nxt         = digit_r;
    started_nxt       = started_r;
    out_valid_nxt     = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    case (state_r)
      sitda_pkg::ST_IDLE: begin
        if (accept) begin
          // two's complement negate also gives 2^31 for the most negative value
          mag_nxt     = in_value[sitda_pkg::ValueW-1]
                        ? (~in_value + sitda_pkg::ValueW'(1)) : in_value;
          pos_nxt     = sitda_pkg::TopPos;
          bit_nxt     = sitda_pkg::TopBit;
          digit_nxt   = '0;
          started_nxt = 1'b0;
        end
      end
      sitda_pkg::ST_SIGN: begin
        out_valid_nxt     = 1'b1;
        out_character_nxt = sitda_pkg::ChMinus;
        out_last_nxt      = 1'b0;
      end
      sitda_pkg::ST_DIGIT: begin
        if (ge) begin
          mag_nxt = trial[sitda_pkg::ValueW-1:0];
        end
        if (bit_r == '0) begin
          out_valid_nxt     = emit;
          out_character_nxt = sitda_pkg::ChZero
                              + {{(sitda_pkg::CharW-sitda_pkg::DigitW){1'b0}}, digit_full};
          out_last_nxt      = (pos_r == '0);
          started_nxt       = started_r || emit;
          digit_nxt         = '0;
          bit_nxt           = sitda_pkg::TopBit;
          pos_nxt           = pos_r - sitda_pkg::PosW'(1);
        end else begin
          digit_nxt = digit_full;
          bit_nxt   = bit_r - sitda_pkg::BitW'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r           <= mag_nxt;
    pos_r           <= pos_nxt;
    bit_r           <= bit_nxt;
    digit_r         <= digit_nxt;
    started_r       <= started_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == sitda_pkg::ChMinus)
                  || ((out_character >= sitda_pkg::ChZero)
                      && (out_character <= sitda_pkg::ChNine)))
    else $error("illegal character on output");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == sitda_pkg::ChMinus)) |-> !out_last)
    else $error("minus sign flagged as last");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy still high with last character");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

endmodule

[tb/tb_signed_int_to_decimal_ascii_unit.sv]
// Self-checking testbench for the signed integer to decimal ASCII unit.
module tb_signed_int_to_decimal_ascii_unit;

  localparam int unsigned NumDirected   = 23;
  localparam int unsigned RandPerPhase  = 167;
  localparam int unsigned QuietLimit    = 1000;
  localparam int unsigned DrainCycles   = 48;

  typedef struct packed {
    logic [sitda_pkg::CharW-1:0] ch;
    logic                        last;
  } text_char_t;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           start    = 1'b0;
  logic [sitda_pkg::ValueW-1:0]   in_value = '0;
  logic                           busy;
  logic                           out_valid;
  logic [sitda_pkg::CharW-1:0]    out_character;
  logic                           out_last;

  text_char_t expected_chars[$];
  int unsigned mismatches     = 0;
  int unsigned numbers_sent   = 0;
  int unsigned negatives_sent = 0;
  int unsigned chars_checked  = 0;
  int unsigned quiet_cycles   = 0;

  // Directed rows; an empty text means the predictor supplies the expectation.
  logic [sitda_pkg::ValueW-1:0] dir_value [NumDirected] = '{
    32'd0, 32'd1, -32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd9, 32'd10, -32'd9,
    32'd1000000000, -32'd1000000000, 32'd999999999, 32'h8000_0001,
    32'd123456789, -32'd987654321, 32'd100, -32'd100, 32'd99, 32'h5555_5555,
    32'hAAAA_AAAA, 32'd1073741824, -32'd5, 32'd4095, -32'd65536
  };
  string dir_text [NumDirected] = '{
    "0", "1", "-1", "2147483647", "-2147483648", "9", "10", "-9",
    "1000000000", "-1000000000", "999999999", "-2147483647",
    "", "", "", "", "", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  // Decimal text of a 32-bit two's complement number; the magnitude is taken
  // unsigned so the most negative value needs no special path.
  function automatic string decimal_text(input logic [sitda_pkg::ValueW-1:0] v);
    logic [sitda_pkg::ValueW-1:0] mag;
    string                        s;
    mag = v[sitda_pkg::ValueW-1] ? (~v + 32'd1) : v;
    s = "";
    do begin
      s = $sformatf("%0d%s", mag % 32'd10, s);
      mag = mag / 32'd10;
    end while (mag != 0);
    if (v[sitda_pkg::ValueW-1]) s = {"-", s};
    return s;
  endfunction

  task automatic queue_text(input string s);
    text_char_t  c;
    logic [7:0]  b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      c.ch = b[sitda_pkg::CharW-1:0];
      c.last = (i == s.len() - 1);
      expected_chars.push_back(c);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH t=%0t: %s", $time, what);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_number(input logic [sitda_pkg::ValueW-1:0] v, input string typed,
                             input int unsigned idle_pct);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = 1;
      while ($urandom_range(99) < idle_pct) gap++;
      if ($urandom_range(9) == 0) gap += $urandom_range(44);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    numbers_sent++;
    if (v[sitda_pkg::ValueW-1]) negatives_sent++;
    queue_text((typed.len() != 0) ? typed : decimal_text(v));
  endtask

  function automatic logic [sitda_pkg::ValueW-1:0] pick_number();
    longint unsigned lim;
    longint unsigned mag;
    int unsigned     sel;
    sel = $urandom_range(9);
    if (sel <= 3) return $urandom;
    lim = 1;
    repeat ((sel <= 7) ? $urandom_range(1, 10) : $urandom_range(0, 9)) lim *= 10;
    if (sel <= 7) begin
      mag = {$urandom, $urandom} % lim;
    end else begin
      // around a power of ten, where the digit count changes
      mag = lim + $urandom_range(2) - 1;
    end
    if ($urandom_range(1)) begin
      mag = (mag > 64'd2147483648) ? 64'd2147483648 : mag;
      return -mag[sitda_pkg::ValueW-1:0];
    end
    mag = (mag > 64'd2147483647) ? 64'd2147483647 : mag;
    return mag[sitda_pkg::ValueW-1:0];
  endfunction

  always @(posedge clk) begin : check_output
    text_char_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d", out_character));
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_character !== want.ch)
          report_mismatch($sformatf("character %0d, expected %0d", out_character, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last flag %0b, expected %0b on character %0d",
                                    out_last, want.last, want.ch));
      end
    end
  end

  // Cycles with neither an input transfer nor a character count toward the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("signed_int_to_decimal_ascii_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pacing [3];
    pacing = '{23, 68, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumDirected; i++) send_number(dir_value[i], dir_text[i], 0);
    for (int p = 0; p < 3; p++)
      for (int i = 0; i < RandPerPhase; i++) send_number(pick_number(), "", pacing[p]);
    start <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d numbers (%0d negative), %0d characters checked,",
             numbers_sent, negatives_sent, chars_checked);
    $display("with sender gaps at two densities and then back-to-back starts.");
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("signed_int_to_decimal_ascii_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sitda_pkg.sv
src/signed_int_to_decimal_ascii_unit.sv
tb/tb_signed_int_to_decimal_ascii_unit.sv
